### src/bwdt_pkg.sv
// shared types and constants for the two-stage bus watchdog
// request codes, register offsets and the channel payload structs; no dependencies
package bwdt_pkg;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_CFG_WR   = 3'd1;
  localparam logic [2:0] REQ_CFG_RD   = 3'd2;
  localparam logic [2:0] REQ_WIN_WR   = 3'd3;
  localparam logic [2:0] REQ_WIN_RD   = 3'd4;

  localparam logic [2:0] SIZE_BYTE    = 3'd1;
  localparam logic [2:0] SIZE_HALF    = 3'd2;
  localparam logic [2:0] SIZE_WORD    = 3'd4;

  localparam logic [7:0] CFG_CTRL     = 8'h60;
  localparam logic [7:0] CFG_LOCK     = 8'h68;
  localparam logic [7:0] WIN_PRE1     = 8'h00;
  localparam logic [7:0] WIN_PRE2     = 8'h04;
  localparam logic [7:0] WIN_RELOAD   = 8'h0c;

  localparam logic [31:0] UNLOCK_KEY1 = 32'h80;
  localparam logic [31:0] UNLOCK_KEY2 = 32'h86;
  localparam logic [15:0] RD_REBOOTED = 16'h1200;

  localparam logic [1:0] UNLOCK_IDLE  = 2'd0;
  localparam logic [1:0] UNLOCK_HALF  = 2'd1;
  localparam logic [1:0] UNLOCK_OPEN  = 2'd2;

  localparam logic [1:0] INT_IRQ      = 2'd0;
  localparam logic [1:0] INT_SMI      = 2'd2;

  localparam int SLOW_SHIFT = 15;
  localparam int FAST_SHIFT = 5;

  localparam int RELOAD_BIT = 8;
  localparam int CLR_BIT_A  = 9;
  localparam int CLR_BIT_B  = 12;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  addr;
    logic [2:0]  access_size;
    logic [31:0] wdata;
  } bwdt_req_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        irq_event;
    logic        smi_event;
    logic        reboot_event;
  } bwdt_rsp_t;

endpackage

### src/bwdt_req_if.sv
// request channel: valid/ready handshake carrying one bus access or tick
// depends on bwdt_pkg
interface bwdt_req_if;
  import bwdt_pkg::*;

  logic      valid;
  logic      ready;
  bwdt_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/bwdt_rsp_if.sv
// response channel: valid/ready handshake carrying read data and event pulses
// depends on bwdt_pkg
interface bwdt_rsp_if;
  import bwdt_pkg::*;

  logic      valid;
  logic      ready;
  bwdt_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/bwdt_in_stage.sv
// input register of the watchdog pipeline
// depends on bwdt_pkg and bwdt_req_if
module bwdt_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  bwdt_req_if.sink           req_i,
  input  logic               advance_i,
  output logic               valid_o,
  output bwdt_pkg::bwdt_req_t data_o
);
  import bwdt_pkg::*;

  logic      valid_q;
  bwdt_req_t data_q;

  assign req_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= req_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### src/bwdt_core.sv
// watchdog registers, unlock sequence and two-stage countdown
// depends on bwdt_pkg; state advances once per item leaving the input register
module bwdt_core #(
  parameter int PRELOAD_WIDTH = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  bwdt_pkg::bwdt_req_t req_i,
  output bwdt_pkg::bwdt_rsp_t rsp_o
);
  import bwdt_pkg::*;

  localparam int CW = PRELOAD_WIDTH + SLOW_SHIFT;

  logic                     reboot_on_q, reboot_on_d;
  logic                     fast_q, fast_d;
  logic [1:0]               kind_q, kind_d;
  logic                     free_q, free_d;
  logic                     lock_q, lock_d;
  logic                     en_q, en_d;
  logic [PRELOAD_WIDTH-1:0] pre1_q, pre1_d;
  logic [PRELOAD_WIDTH-1:0] pre2_q, pre2_d;
  logic                     stage2_q, stage2_d;
  logic [1:0]               unlock_q, unlock_d;
  logic                     prior_q, prior_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     counting_q, counting_d;

  logic [31:0]              v;
  logic                     size_ok;
  logic                     old_en;
  logic                     start;
  logic                     start_second;
  bwdt_rsp_t                rsp;

  always_comb begin
    reboot_on_d  = reboot_on_q;
    fast_d       = fast_q;
    kind_d       = kind_q;
    free_d       = free_q;
    lock_d       = lock_q;
    en_d         = en_q;
    pre1_d       = pre1_q;
    pre2_d       = pre2_q;
    stage2_d     = stage2_q;
    unlock_d     = unlock_q;
    prior_d      = prior_q;
    count_d      = count_q;
    counting_d   = counting_q;
    rsp          = '0;
    old_en       = en_q;
    start        = 1'b0;
    start_second = 1'b0;

    case (req_i.access_size)
      SIZE_BYTE: v = {24'h0, req_i.wdata[7:0]};
      SIZE_HALF: v = {16'h0, req_i.wdata[15:0]};
      default:   v = req_i.wdata;
    endcase
    size_ok = (req_i.access_size == SIZE_BYTE) || (req_i.access_size == SIZE_HALF) ||
              (req_i.access_size == SIZE_WORD);

    case (req_i.req_type)
      REQ_TICK: begin
        if (counting_q) begin
          if (count_q > CW'(1)) begin
            count_d = count_q - CW'(1);
          end else begin
            count_d    = '0;
            counting_d = 1'b0;
            if (!stage2_q) begin
              rsp.irq_event = (kind_q == INT_IRQ);
              rsp.smi_event = (kind_q == INT_SMI);
              start        = 1'b1;
              start_second = 1'b1;
            end else begin
              if (reboot_on_q) begin
                prior_d          = 1'b1;
                rsp.reboot_event = 1'b1;
                reboot_on_d      = 1'b1;
                fast_d           = 1'b0;
                kind_d           = INT_IRQ;
                free_d           = 1'b0;
                lock_d           = 1'b0;
                en_d             = 1'b0;
                pre1_d           = '1;
                pre2_d           = '1;
                stage2_d         = 1'b0;
                unlock_d         = UNLOCK_IDLE;
              end
              start = free_d;
            end
          end
        end
      end
      REQ_CFG_WR: begin
        if (req_i.addr == CFG_CTRL && req_i.access_size == SIZE_HALF) begin
          reboot_on_d = !v[5];
          fast_d      = v[2];
          kind_d      = v[1:0];
        end else if (req_i.addr == CFG_LOCK && req_i.access_size == SIZE_BYTE && !lock_q) begin
          lock_d = v[0];
          free_d = v[2];
          en_d   = v[1];
          if (!old_en && en_d) begin
            start = 1'b1;
          end else if (!en_d) begin
            counting_d = 1'b0;
          end
        end
      end
      REQ_CFG_RD: begin
        if (req_i.addr == CFG_CTRL && req_i.access_size == SIZE_HALF) begin
          rsp.rdata = {10'h0, !reboot_on_q, 2'b00, fast_q, kind_q};
        end else if (req_i.addr == CFG_LOCK && req_i.access_size == SIZE_BYTE) begin
          rsp.rdata = {13'h0, free_q, en_q, lock_q};
        end
      end
      REQ_WIN_WR: begin
        if (size_ok) begin
          if (req_i.addr == WIN_RELOAD && v == UNLOCK_KEY1) begin
            unlock_d = UNLOCK_HALF;
          end else if (req_i.addr == WIN_RELOAD && v == UNLOCK_KEY2 &&
                       unlock_q == UNLOCK_HALF) begin
            unlock_d = UNLOCK_OPEN;
          end else if (req_i.access_size != SIZE_BYTE && unlock_q == UNLOCK_OPEN) begin
            if (req_i.access_size == SIZE_HALF && req_i.addr == WIN_RELOAD) begin
              start = v[RELOAD_BIT];
              if (v[CLR_BIT_A] || v[CLR_BIT_B]) begin
                prior_d = 1'b0;
              end
            end else if (req_i.access_size == SIZE_WORD && req_i.addr == WIN_PRE1) begin
              pre1_d = v[PRELOAD_WIDTH-1:0];
            end else if (req_i.access_size == SIZE_WORD && req_i.addr == WIN_PRE2) begin
              pre2_d = v[PRELOAD_WIDTH-1:0];
            end
            unlock_d = UNLOCK_IDLE;
          end
        end
      end
      REQ_WIN_RD: begin
        if (req_i.addr == WIN_RELOAD && req_i.access_size == SIZE_HALF) begin
          rsp.rdata = prior_q ? RD_REBOOTED : 16'h0;
        end
      end
      default: begin
      end
    endcase

    // stage start only takes effect while the timer is enabled
    if (start && en_d) begin
      stage2_d   = start_second;
      count_d    = (start_second ? CW'(pre2_d) : CW'(pre1_d)) <<
                   (fast_d ? FAST_SHIFT : SLOW_SHIFT);
      counting_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reboot_on_q <= 1'b1;
      fast_q      <= 1'b0;
      kind_q      <= INT_IRQ;
      free_q      <= 1'b0;
      lock_q      <= 1'b0;
      en_q        <= 1'b0;
      pre1_q      <= '1;
      pre2_q      <= '1;
      stage2_q    <= 1'b0;
      unlock_q    <= UNLOCK_IDLE;
      prior_q     <= 1'b0;
      count_q     <= '0;
      counting_q  <= 1'b0;
    end else if (fire_i) begin
      reboot_on_q <= reboot_on_d;
      fast_q      <= fast_d;
      kind_q      <= kind_d;
      free_q      <= free_d;
      lock_q      <= lock_d;
      en_q        <= en_d;
      pre1_q      <= pre1_d;
      pre2_q      <= pre2_d;
      stage2_q    <= stage2_d;
      unlock_q    <= unlock_d;
      prior_q     <= prior_d;
      count_q     <= count_d;
      counting_q  <= counting_d;
    end
  end

  assign rsp_o = rsp;
endmodule

### src/bwdt_out_stage.sv
// result register of the watchdog pipeline
// depends on bwdt_pkg and bwdt_rsp_if
module bwdt_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bwdt_pkg::bwdt_rsp_t data_i,
  output logic                free_o,
  bwdt_rsp_if.source          rsp_o
);
  import bwdt_pkg::*;

  logic      valid_q;
  bwdt_rsp_t data_q;

  assign free_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid   = valid_q;
  assign rsp_o.payload = data_q;
endmodule

### src/two_stage_bus_watchdog.sv
// two-stage bus watchdog top level
// depends on bwdt_pkg, bwdt_req_if, bwdt_rsp_if, bwdt_in_stage, bwdt_core, bwdt_out_stage
//
// usage:
//   req_i carries one item per transfer: a tick or a config/window
//   read or write. rsp_o returns exactly one result per request, in order:
//   rdata for reads (zero otherwise) and event flags for irq,
//   smi and reboot.
//   the result passes the input register, then the result register,
//   before it is valid and can be taken. while the receiver keeps up,
//   one request is taken every cycle; the pace is set by the single pass
//   through the core logic between the two registers.
//   when the receiver stalls, the result register holds and the input
//   register fills; req_i.ready drops only when both are occupied.
//   reset clears both registers and puts every watchdog register at its
//   power-on value, including the previous-reboot flag. a reboot caused by
//   stage two expiry restores all registers except that flag.
module two_stage_bus_watchdog #(
  parameter int PRELOAD_WIDTH = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bwdt_req_if.sink   req_i,
  bwdt_rsp_if.source rsp_o
);
  import bwdt_pkg::*;

  logic      in_valid;
  bwdt_req_t in_data;
  logic      out_free;
  logic      advance;
  bwdt_rsp_t core_rsp;

  assign advance = in_valid && out_free;

  bwdt_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .data_o    (in_data)
  );

  bwdt_core #(
    .PRELOAD_WIDTH (PRELOAD_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_data),
    .rsp_o  (core_rsp)
  );

  bwdt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .data_i (core_rsp),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );
endmodule

### sim/bwdt_checker.sv
// result checker for the two-stage bus watchdog: predicts every result from the
// accepted requests and compares it field by field with the accepted results
// depends on bwdt_pkg, bwdt_req_if, bwdt_rsp_if
module bwdt_checker #(
  parameter int PRELOAD_WIDTH = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  bwdt_req_if  req_i,
  bwdt_rsp_if  rsp_i,
  output int   errors_o,
  output int   pending_o
);
  import bwdt_pkg::*;

  localparam int CNT_W = PRELOAD_WIDTH + SLOW_SHIFT;

  logic                     reboot_on, fast_clk, auto_rearm, locked, enabled;
  logic                     stage2, counting, rebooted;
  logic [1:0]               int_kind, unlock_st;
  logic [PRELOAD_WIDTH-1:0] pre1, pre2;
  logic [CNT_W-1:0]         ticks_left;

  bwdt_rsp_t expected_q[$];
  bwdt_rsp_t want, got;
  logic      bad;
  int        mismatches = 0;
  int        n_pending = 0;

  assign errors_o  = mismatches;
  assign pending_o = n_pending;

  function automatic void clear_device();
    reboot_on  = 1'b1;
    fast_clk   = 1'b0;
    int_kind   = INT_IRQ;
    auto_rearm = 1'b0;
    locked     = 1'b0;
    enabled    = 1'b0;
    pre1       = '1;
    pre2       = '1;
    stage2     = 1'b0;
    unlock_st  = UNLOCK_IDLE;
    ticks_left = '0;
    counting   = 1'b0;
  endfunction

  function automatic void load_stage(logic second);
    logic [CNT_W-1:0] base;
    if (!enabled) return;
    stage2     = second;
    base       = second ? CNT_W'(pre2) : CNT_W'(pre1);
    ticks_left = base << (fast_clk ? FAST_SHIFT : SLOW_SHIFT);
    counting   = 1'b1;
  endfunction

  function automatic bwdt_rsp_t predict_access(bwdt_req_t r);
    bwdt_rsp_t   res;
    logic [31:0] d;
    logic        was_en;
    res = '0;
    d   = r.wdata;
    if (r.access_size == SIZE_BYTE) d = d & 32'h0000_00ff;
    else if (r.access_size == SIZE_HALF) d = d & 32'h0000_ffff;
    case (r.req_type)
      REQ_TICK: begin
        if (counting) begin
          if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
          end else begin
            ticks_left = '0;
            counting   = 1'b0;
            if (!stage2) begin
              if (int_kind == INT_IRQ) res.irq_event = 1'b1;
              else if (int_kind == INT_SMI) res.smi_event = 1'b1;
              load_stage(1'b1);
            end else begin
              if (reboot_on) begin
                rebooted         = 1'b1;
                res.reboot_event = 1'b1;
                clear_device();
              end
              if (auto_rearm) load_stage(1'b0);
            end
          end
        end
      end
      REQ_CFG_WR: begin
        if (r.addr == CFG_CTRL && r.access_size == SIZE_HALF) begin
          reboot_on = !d[5];
          fast_clk  = d[2];
          int_kind  = d[1:0];
        end else if (r.addr == CFG_LOCK && r.access_size == SIZE_BYTE && !locked) begin
          was_en     = enabled;
          locked     = d[0];
          auto_rearm = d[2];
          enabled    = d[1];
          if (!was_en && enabled) load_stage(1'b0);
          else if (!enabled) counting = 1'b0;
        end
      end
      REQ_CFG_RD: begin
        if (r.addr == CFG_CTRL && r.access_size == SIZE_HALF)
          res.rdata = {10'd0, !reboot_on, 2'b00, fast_clk, int_kind};
        else if (r.addr == CFG_LOCK && r.access_size == SIZE_BYTE)
          res.rdata = {13'd0, auto_rearm, enabled, locked};
      end
      REQ_WIN_WR: begin
        if (r.access_size == SIZE_BYTE || r.access_size == SIZE_HALF ||
            r.access_size == SIZE_WORD) begin
          if (r.addr == WIN_RELOAD && d == UNLOCK_KEY1) begin
            unlock_st = UNLOCK_HALF;
          end else if (r.addr == WIN_RELOAD && d == UNLOCK_KEY2 &&
                       unlock_st == UNLOCK_HALF) begin
            unlock_st = UNLOCK_OPEN;
          end else if (r.access_size != SIZE_BYTE && unlock_st == UNLOCK_OPEN) begin
            if (r.access_size == SIZE_HALF && r.addr == WIN_RELOAD) begin
              if (d[RELOAD_BIT]) load_stage(1'b0);
              if (d[CLR_BIT_A] || d[CLR_BIT_B]) rebooted = 1'b0;
            end else if (r.access_size == SIZE_WORD && r.addr == WIN_PRE1) begin
              pre1 = d[PRELOAD_WIDTH-1:0];
            end else if (r.access_size == SIZE_WORD && r.addr == WIN_PRE2) begin
              pre2 = d[PRELOAD_WIDTH-1:0];
            end
            unlock_st = UNLOCK_IDLE;
          end
        end
      end
      REQ_WIN_RD: begin
        if (r.addr == WIN_RELOAD && r.access_size == SIZE_HALF)
          res.rdata = rebooted ? RD_REBOOTED : 16'h0000;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_device();
      rebooted = 1'b0;
      expected_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.payload;
        if (expected_q.size() == 0) begin
          $display("%0t: result %h with none expected", $time, got);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          bad  = 1'b0;
          if (got.rdata !== want.rdata) begin
            $display("%0t: rdata expected %h got %h", $time, want.rdata, got.rdata);
            bad = 1'b1;
          end
          if (got.irq_event !== want.irq_event) begin
            $display("%0t: irq_event expected %b got %b", $time, want.irq_event,
                     got.irq_event);
            bad = 1'b1;
          end
          if (got.smi_event !== want.smi_event) begin
            $display("%0t: smi_event expected %b got %b", $time, want.smi_event,
                     got.smi_event);
            bad = 1'b1;
          end
          if (got.reboot_event !== want.reboot_event) begin
            $display("%0t: reboot_event expected %b got %b", $time, want.reboot_event,
                     got.reboot_event);
            bad = 1'b1;
          end
          if (bad) mismatches++;
        end
      end
      if (req_i.valid && req_i.ready) expected_q.push_back(predict_access(req_i.payload));
    end
    n_pending = expected_q.size();
  end

endmodule

### sim/tb.sv
// testbench top for the two-stage bus watchdog: clock, reset, request stimulus
// with idle and stall phases, and the verdict
// depends on bwdt_pkg, bwdt_req_if, bwdt_rsp_if, two_stage_bus_watchdog, bwdt_checker
module tb;
  import bwdt_pkg::*;

  localparam int PRELOAD_WIDTH = 20;
  localparam int RAND_ITEMS    = 400;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk_i;
  logic rst_ni;
  int   errors, pending;
  int   sent_items = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;

  bwdt_req_if req_ch ();
  bwdt_rsp_if rsp_ch ();

  two_stage_bus_watchdog #(.PRELOAD_WIDTH(PRELOAD_WIDTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  bwdt_checker #(.PRELOAD_WIDTH(PRELOAD_WIDTH)) checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_ch),
    .rsp_i    (rsp_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block fills up
  initial begin
    int hold_left;
    bit hold_done;
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && sent_items >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send(input logic [2:0] kind, input logic [7:0] where,
                      input logic [2:0] size, input logic [31:0] data);
    bwdt_req_t item;
    item.req_type    = kind;
    item.addr        = where;
    item.access_size = size;
    item.wdata       = data;
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.payload <= item;
    req_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_items++;
  endtask

  function automatic logic [2:0] any_size();
    case ($urandom_range(2))
      0:       return SIZE_BYTE;
      1:       return SIZE_HALF;
      default: return SIZE_WORD;
    endcase
  endfunction

  // junk in the byte lanes above the access width
  function automatic logic [31:0] fill_upper_lanes(logic [2:0] size, logic [31:0] v);
    logic [31:0] r;
    r = $urandom;
    if (size == SIZE_BYTE) return {r[31:8], v[7:0]};
    if (size == SIZE_HALF) return {r[31:16], v[15:0]};
    return v;
  endfunction

  task automatic open_window();
    logic [2:0] sz;
    sz = any_size();
    send(REQ_WIN_WR, WIN_RELOAD, sz, fill_upper_lanes(sz, UNLOCK_KEY1));
    sz = any_size();
    send(REQ_WIN_WR, WIN_RELOAD, sz, fill_upper_lanes(sz, UNLOCK_KEY2));
  endtask

  task automatic random_sequence();
    int          pick, n;
    logic        fast;
    logic [2:0]  k, s;
    logic [7:0]  a;
    logic [31:0] v;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // noise
      k = 3'($urandom);
      a = ($urandom_range(1)) ? 8'($urandom) : 8'(4 * $urandom_range(3));
      if ($urandom_range(3) == 0) a = CFG_CTRL;
      if ($urandom_range(3) == 0) a = CFG_LOCK;
      s = 3'($urandom);
      v = $urandom;
      if (k == REQ_CFG_WR && a == CFG_LOCK && v[0]) v[1] = 1'b1;
      send(k, a, s, v);
    end else if (pick < 30) begin
      // program control, preloads, then enable
      fast    = ($urandom_range(4) != 0);
      v       = $urandom;
      v[5]    = ($urandom_range(3) == 0);
      v[2]    = fast;
      v[1:0]  = 2'($urandom_range(3));
      send(REQ_CFG_WR, CFG_CTRL, SIZE_HALF, v);
      open_window();
      v = $urandom;
      v[PRELOAD_WIDTH-1:0] = fast ? PRELOAD_WIDTH'($urandom_range(2)) : '0;
      send(REQ_WIN_WR, WIN_PRE1, SIZE_WORD, v);
      open_window();
      v = $urandom;
      v[PRELOAD_WIDTH-1:0] = fast ? PRELOAD_WIDTH'($urandom_range(2)) : '0;
      send(REQ_WIN_WR, WIN_PRE2, SIZE_WORD, v);
      v      = $urandom;
      v[1:0] = 2'b00;
      send(REQ_CFG_WR, CFG_LOCK, SIZE_BYTE, v);
      v    = $urandom;
      v[1] = ($urandom_range(9) != 0);
      v[0] = v[1] && ($urandom_range(4) == 0);
      send(REQ_CFG_WR, CFG_LOCK, SIZE_BYTE, v);
    end else if (pick < 45) begin
      // reload or flag clear, sometimes with a broken unlock
      if ($urandom_range(9) == 0) begin
        send(REQ_WIN_WR, WIN_RELOAD, SIZE_HALF, UNLOCK_KEY1);
        send(REQ_WIN_WR, 8'($urandom), SIZE_BYTE, $urandom);
      end else begin
        open_window();
      end
      v             = $urandom;
      v[RELOAD_BIT] = ($urandom_range(3) != 0);
      v[CLR_BIT_A]  = ($urandom_range(3) == 0);
      v[CLR_BIT_B]  = ($urandom_range(3) == 0);
      s = ($urandom_range(5) == 0) ? SIZE_WORD : SIZE_HALF;
      send(REQ_WIN_WR, WIN_RELOAD, s, v);
    end else if (pick < 55) begin
      case ($urandom_range(3))
        0:       send(REQ_CFG_RD, CFG_CTRL, SIZE_HALF, $urandom);
        1:       send(REQ_CFG_RD, CFG_LOCK, SIZE_BYTE, $urandom);
        2:       send(REQ_WIN_RD, WIN_RELOAD, SIZE_HALF, $urandom);
        default: send(REQ_WIN_RD, WIN_RELOAD, 3'($urandom), $urandom);
      endcase
    end else begin
      n = $urandom_range(1, 24);
      repeat (n) send(REQ_TICK, 8'($urandom), 3'($urandom), $urandom);
    end
  endtask

  initial begin
    int rand_start;
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // power-on values
    send(REQ_CFG_RD, CFG_CTRL, SIZE_HALF, 32'h0);
    send(REQ_CFG_RD, CFG_LOCK, SIZE_BYTE, 32'h0);
    send(REQ_WIN_RD, WIN_RELOAD, SIZE_HALF, 32'h0);
    // all-ones control: reboot off, fast, unused interrupt kind
    send(REQ_CFG_WR, CFG_CTRL, SIZE_HALF, 32'hffff_ffff);
    send(REQ_CFG_RD, CFG_CTRL, SIZE_HALF, 32'hffff_ffff);
    send(REQ_CFG_WR, CFG_CTRL, SIZE_HALF, 32'hffff_0004);
    // unlock with junk lanes; a byte write does not use it up
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_BYTE, 32'hffff_ff80);
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_HALF, 32'hffff_0086);
    send(REQ_WIN_WR, WIN_PRE1, SIZE_BYTE, 32'h0);
    send(REQ_WIN_WR, WIN_PRE1, SIZE_WORD, 32'hfff0_0000);
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_WORD, UNLOCK_KEY1);
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_WORD, UNLOCK_KEY2);
    send(REQ_WIN_WR, WIN_PRE2, SIZE_WORD, 32'hfff0_0000);
    // enable and lock; zero counts expire on the first tick, then reboot
    send(REQ_CFG_WR, CFG_LOCK, SIZE_BYTE, 32'hffff_ff03);
    send(REQ_TICK, 8'hff, 3'h7, 32'hffff_ffff);
    send(REQ_TICK, 8'h00, 3'h0, 32'h0);
    send(REQ_WIN_RD, WIN_RELOAD, SIZE_HALF, 32'h0);
    // restart while disabled, flag clear
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_HALF, UNLOCK_KEY1);
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_HALF, UNLOCK_KEY2);
    send(REQ_WIN_WR, WIN_RELOAD, SIZE_HALF, 32'hffff_1300);
    send(REQ_TICK, 8'h00, SIZE_BYTE, 32'h0);
    send(REQ_WIN_RD, WIN_RELOAD, SIZE_HALF, 32'h0);
    // unused request types and sizes
    send(3'd7, CFG_CTRL, 3'd3, 32'hffff_ffff);
    send(3'd5, CFG_LOCK, SIZE_BYTE, 32'h0000_0003);
    send(REQ_CFG_RD, CFG_CTRL, 3'd3, 32'h0);
    send(REQ_CFG_WR, CFG_CTRL, SIZE_HALF, 32'h0000_0006);

    rand_start = sent_items;
    while (sent_items < rand_start + RAND_ITEMS) begin
      case (((sent_items - rand_start) * 4) / RAND_ITEMS)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 62;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 62;
        end
        default: begin
          gap_pct   = 17;
          stall_pct = 17;
        end
      endcase
      random_sequence();
    end
    req_ch.valid <= 1'b0;
    stall_pct = 0;

    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
